/* design/msp_pkg.sv */
package msp_pkg;

    localparam int NUM_SLOTS    = 4;
    localparam int PERIOD_TICKS = 100;

    localparam int NUM_REGS   = 4;
    localparam int REG_W      = 16;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int SLOT_W     = 2;
    localparam int NUM_PHASES = 2 * NUM_SLOTS;
    localparam int PH_W       = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
    localparam int POS_W      = $clog2(NUM_PHASES + 1);

    localparam logic [REG_W-1:0] PERIOD      = REG_W'(PERIOD_TICKS);
    localparam logic [REG_W-1:0] INTERVAL_RST = REG_W'(50);

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_REQ  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ALT   = 2'd1,
        MODE_PULSE = 2'd2,
        MODE_THIRD = 2'd3
    } t_mode;

    typedef struct packed {
        t_kind kind;
        t_mode requested_mode;
    } t_in_word;

    typedef struct packed {
        t_mode mode_now;
        logic  alt_pin;
        logic  pulse_pin;
        logic  third_pin;
        logic  train_busy;
        logic  rejected;
    } t_out_word;

endpackage

/* design/mode_select_pulse_train.sv */
// mode select and pulse train
// input channel (i_in_valid / o_in_ready / i_in_word) carries one word per tick
// or mode change request; output channel (o_out_valid / i_out_ready /
// o_out_word) returns exactly one result word per input word, in order.
// config port: i_cfg_we writes i_cfg_data into interval register i_cfg_idx
// (high time of slots 0..3, clamped to the period); write only while idle.
// the result of an accepted word is registered and shows after the edge that
// accepts it. one word per cycle is sustained unless the receiver stalls,
// set by the single pass of clamp, phase search and counter update between
// the state and result registers. o_in_ready is high while the result
// register is empty or being taken, so a stalled receiver holds the result
// and stops new input after one word. reset clears mode, pins, pulse train
// state and the result valid; interval registers return to 50 ticks each.
module mode_select_pulse_train
    import msp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data
);

    logic [REG_W-1:0]  r_interval [NUM_REGS];
    t_mode             r_mode, n_mode;
    logic              r_running, n_running;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_low, n_low;
    logic [REG_W-1:0]  r_count, n_count;
    logic [2:0]        r_pins, n_pins;
    logic              r_out_valid;
    t_out_word         r_out, n_out;

    logic              accept;
    logic              n_rejected;
    logic              do_enter;
    logic [POS_W-1:0]  start_pos;
    logic [REG_W-1:0]  phase_len [NUM_PHASES];
    logic              found;
    logic [PH_W-1:0]   found_pos;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // a tick moves on from the current phase, a request can only start the train
    assign start_pos = (i_in_word.kind == KIND_TICK) ?
                       POS_W'({r_slot, r_low}) + POS_W'(1) : '0;

    // phase lengths: even entries high time, odd entries rest of the period
    always_comb begin
        logic [REG_W-1:0] hi;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            hi = (r_interval[s] > PERIOD) ? PERIOD : r_interval[s];
            phase_len[2*s]     = hi;
            phase_len[2*s + 1] = PERIOD - hi;
        end
    end

    // first phase of non-zero length at or after start_pos
    always_comb begin
        found     = 1'b0;
        found_pos = '0;
        for (int p = NUM_PHASES - 1; p >= 0; p--) begin
            if (POS_W'(p) >= start_pos && phase_len[p] != '0) begin
                found     = 1'b1;
                found_pos = PH_W'(p);
            end
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_running  = r_running;
        n_slot     = r_slot;
        n_low      = r_low;
        n_count    = r_count;
        n_pins     = r_pins;
        n_rejected = 1'b0;
        do_enter   = 1'b0;

        if (i_in_word.kind == KIND_TICK) begin
            if (r_running) begin
                if (r_count > REG_W'(1)) begin
                    n_count = r_count - REG_W'(1);
                end else begin
                    do_enter = 1'b1;
                end
            end
        end else if (r_running) begin
            n_rejected = 1'b1;
        end else if (i_in_word.requested_mode == r_mode) begin
            n_rejected = 1'b0;
        end else if (r_mode == MODE_IDLE) begin
            n_mode = i_in_word.requested_mode;
            unique case (i_in_word.requested_mode)
                MODE_ALT: begin
                    n_pins[0] = 1'b1;
                end
                MODE_PULSE: begin
                    n_running = 1'b1;
                    do_enter  = 1'b1;
                end
                MODE_THIRD: begin
                    n_pins[2] = 1'b1;
                end
                default: begin
                    n_pins = r_pins;
                end
            endcase
        end else if (i_in_word.requested_mode != MODE_IDLE) begin
            n_rejected = 1'b1;
        end else begin
            n_mode = MODE_IDLE;
            n_pins = '0;
        end

        if (do_enter) begin
            if (found) begin
                n_slot    = SLOT_W'(found_pos >> 1);
                n_low     = found_pos[0];
                n_count   = phase_len[found_pos];
                n_pins[1] = !found_pos[0];
            end else begin
                // train over, pulse pin left high
                n_running = 1'b0;
                n_low     = 1'b0;
                n_count   = '0;
                n_pins[1] = 1'b1;
            end
        end

        n_out.mode_now   = n_mode;
        n_out.alt_pin    = n_pins[0];
        n_out.pulse_pin  = n_pins[1];
        n_out.third_pin  = n_pins[2];
        n_out.train_busy = n_running;
        n_out.rejected   = n_rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_interval[i] <= INTERVAL_RST;
            end
        end else if (i_cfg_we) begin
            r_interval[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_running   <= 1'b0;
            r_slot      <= '0;
            r_low       <= 1'b0;
            r_count     <= '0;
            r_pins      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode    <= n_mode;
                r_running <= n_running;
                r_slot    <= n_slot;
                r_low     <= n_low;
                r_count   <= n_count;
                r_pins    <= n_pins;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

/* design/msp_checker.sv */
module msp_checker
    import msp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // result word held while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed under stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.mode_now == MODE_IDLE |->
            !o_out_word.alt_pin && !o_out_word.pulse_pin && !o_out_word.third_pin
            && !o_out_word.train_busy)
        else $error("pins not cleared in idle mode");

    a_busy_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.train_busy |->
            o_out_word.mode_now == MODE_PULSE && !o_out_word.alt_pin
            && !o_out_word.third_pin)
        else $error("train running outside pulse mode");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result register full");

endmodule

bind mode_select_pulse_train msp_checker u_msp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
